@@ hw/rtl/cqps_pkg.sv @@
// Shared types, constants and codes of the class queue priority scheduler.
package cqps_pkg;

    localparam int NUM_CLASSES = 5;
    localparam int QUEUE_DEPTH = 1024;

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    localparam int CMD_W      = 2;
    localparam int CSEL_W     = 4;
    localparam int DATA_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int SERVED_W   = 3;
    localparam int PKT_CNT_W  = 32;
    localparam int BYTE_CNT_W = 48;
    localparam int MODE_W     = 2;
    localparam int DCLS_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQ       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ_CLASS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQ_ANY   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Scheduling modes; anything else serves the default class only
    localparam logic [MODE_W-1:0] MODE_HIGH_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW_FIRST  = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_CLASS = 1'd1;

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_DEQ_ONE,
        OP_DEQ_HIGH,
        OP_DEQ_LOW,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [CLS_W-1:0]      cls;
        logic [DATA_W-1:0]     handle;
        logic [DATA_W-1:0]     len;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [DATA_W-1:0]     out_handle;
        logic [DATA_W-1:0]     out_len;
        logic [SERVED_W-1:0]   served_class;
        logic [PKT_CNT_W-1:0]  dropped_total;
        logic [PKT_CNT_W-1:0]  queued_total;
        logic [PKT_CNT_W-1:0]  sent_total;
        logic [BYTE_CNT_W-1:0] bytes_in_total;
        logic [BYTE_CNT_W-1:0] bytes_out_total;
    } res_t;

    typedef enum logic {
        BK_RUN,
        BK_READ
    } back_state_t;

endpackage

@@ hw/rtl/cqps_front.sv @@
// Front end: configuration registers, transaction intake and command classification.
module cqps_front import cqps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [CSEL_W-1:0]     s_class_sel,
    input  logic [DATA_W-1:0]     s_pkt_handle,
    input  logic [DATA_W-1:0]     s_pkt_len,
    output logic                  op_valid,
    input  logic                  op_ready,
    output op_t                   op
);

    logic [MODE_W-1:0] mode_reg;
    logic [DCLS_W-1:0] dclass_reg;
    logic              fv_reg;
    op_t               op_reg;
    op_t               op_next;
    logic [CLS_W-1:0]  eff_def;
    logic              csel_ok;

    assign s_ready  = !fv_reg || op_ready;
    assign op_valid = fv_reg;
    assign op       = op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            dclass_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCHED_MODE:     mode_reg   <= cfg_wdata[MODE_W-1:0];
                CFG_FALLBACK_CLASS: dclass_reg <= cfg_wdata[DCLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range default class saturates to the top class
    always_comb begin
        eff_def = (int'(dclass_reg) < NUM_CLASSES) ? CLS_W'(dclass_reg)
                                                   : CLS_W'(NUM_CLASSES - 1);
        csel_ok = int'(s_class_sel) < NUM_CLASSES;
        op_next.kind   = OP_NOP;
        op_next.cls    = '0;
        op_next.handle = s_pkt_handle;
        op_next.len    = s_pkt_len;
        unique case (s_cmd)
            CMD_ENQ: begin
                op_next.kind = OP_ENQ;
                op_next.cls  = csel_ok ? CLS_W'(s_class_sel) : eff_def;
            end
            CMD_DEQ_CLASS: begin
                if (csel_ok) begin
                    op_next.kind = OP_DEQ_ONE;
                    op_next.cls  = CLS_W'(s_class_sel);
                end
            end
            CMD_DEQ_ANY: begin
                unique case (mode_reg)
                    MODE_HIGH_FIRST: op_next.kind = OP_DEQ_HIGH;
                    MODE_LOW_FIRST:  op_next.kind = OP_DEQ_LOW;
                    default: begin
                        op_next.kind = OP_DEQ_ONE;
                        op_next.cls  = eff_def;
                    end
                endcase
            end
            default: op_next.kind = OP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            fv_reg <= 1'b1;
        end else if (op_ready) begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= op_next;
        end
    end

endmodule

@@ hw/rtl/cqps_cmdq.sv @@
// Two-entry command queue between the front end and the back end.
module cqps_cmdq import cqps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_op,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_op
);

    op_t                   entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic                  push;
    logic                  pop;

    assign in_ready  = count_reg != CMDQ_CNT_W'(CMDQ_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

@@ hw/rtl/cqps_back.sv @@
// Back end: per-class rings, descriptor memory, counters and result register.
module cqps_back import cqps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  op_t  q_op,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [31:0]           slot_mem [SLOTS];
    logic [31:0]           rd_data_reg;
    logic [PTR_W-1:0]      head_reg [NUM_CLASSES];
    logic [PTR_W-1:0]      tail_reg [NUM_CLASSES];
    logic [CNT_W-1:0]      fill_reg [NUM_CLASSES];
    logic [CLS_W-1:0]      sel_reg;
    logic [PKT_CNT_W-1:0]  drop_reg, enq_reg, deq_reg;
    logic [PKT_CNT_W-1:0]  drop_next, enq_next, deq_next;
    logic [BYTE_CNT_W-1:0] enq_bytes_reg, deq_bytes_reg;
    logic [BYTE_CNT_W-1:0] enq_bytes_next, deq_bytes_next;

    logic                  res_valid_reg;
    res_t                  res_reg;
    logic                  out_free;

    logic [NUM_CLASSES-1:0] nonempty;
    logic [CLS_W-1:0]      hi_cls, lo_cls, pick;
    logic                  any_ne, hit, is_enq, is_full;
    logic [ADDR_W-1:0]     slot_addr;

    logic                  q_pop, mem_we, mem_re, load_res;
    logic                  commit_enq, commit_drop, commit_deq;
    logic [STATUS_W-1:0]   st_out;
    logic [DATA_W-1:0]     h_out, l_out;
    logic [CLS_W-1:0]      c_out;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign q_ready   = q_pop;

    // Class selection: priority encoders over the non-empty flags
    always_comb begin
        hi_cls = '0;
        lo_cls = '0;
        any_ne = 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            nonempty[i] = fill_reg[i] != '0;
        end
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (nonempty[i]) begin
                hi_cls = CLS_W'(i);
                any_ne = 1'b1;
            end
        end
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                lo_cls = CLS_W'(i);
            end
        end
        is_enq = 1'b0;
        hit    = 1'b0;
        pick   = '0;
        case (q_op.kind)
            OP_ENQ: begin
                is_enq = 1'b1;
                pick   = q_op.cls;
            end
            OP_DEQ_ONE: begin
                pick = q_op.cls;
                hit  = nonempty[q_op.cls];
            end
            OP_DEQ_HIGH: begin
                pick = hi_cls;
                hit  = any_ne;
            end
            OP_DEQ_LOW: begin
                pick = lo_cls;
                hit  = any_ne;
            end
            default: ;
        endcase
        is_full   = fill_reg[pick] == CNT_W'(QUEUE_DEPTH);
        slot_addr = ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH)
                  + ADDR_W'(is_enq ? tail_reg[pick] : head_reg[pick]);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN: begin
                if (q_valid && !is_enq && hit) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                if (out_free) begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    always_comb begin
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        load_res    = 1'b0;
        commit_enq  = 1'b0;
        commit_drop = 1'b0;
        commit_deq  = 1'b0;
        st_out      = ST_EMPTY;
        h_out       = '0;
        l_out       = '0;
        c_out       = '0;
        unique case (state_reg)
            BK_RUN: begin
                if (q_valid) begin
                    if (is_enq) begin
                        if (out_free) begin
                            q_pop    = 1'b1;
                            load_res = 1'b1;
                            c_out    = pick;
                            if (is_full) begin
                                commit_drop = 1'b1;
                                st_out      = ST_DROP;
                            end else begin
                                mem_we     = 1'b1;
                                commit_enq = 1'b1;
                                st_out     = ST_OK;
                            end
                        end
                    end else if (hit) begin
                        // descriptor read; the result is loaded from it in BK_READ once the output is free
                        q_pop      = 1'b1;
                        mem_re     = 1'b1;
                        commit_deq = 1'b1;
                    end else if (out_free) begin
                        q_pop    = 1'b1;
                        load_res = 1'b1;
                    end
                end
            end
            BK_READ: begin
                if (out_free) begin
                    load_res = 1'b1;
                    st_out   = ST_OK;
                    h_out    = rd_data_reg[31:16];
                    l_out    = rd_data_reg[15:0];
                    c_out    = sel_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        drop_next      = drop_reg + PKT_CNT_W'(commit_drop);
        enq_next       = enq_reg + PKT_CNT_W'(commit_enq);
        deq_next       = deq_reg + PKT_CNT_W'(commit_deq);
        enq_bytes_next = enq_bytes_reg + (commit_enq ? BYTE_CNT_W'(q_op.len) : '0);
        deq_bytes_next = deq_bytes_reg
                       + ((state_reg == BK_READ && load_res) ? BYTE_CNT_W'(l_out) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_RUN;
            res_valid_reg <= 1'b0;
            drop_reg      <= '0;
            enq_reg       <= '0;
            deq_reg       <= '0;
            enq_bytes_reg <= '0;
            deq_bytes_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            drop_reg      <= drop_next;
            enq_reg       <= enq_next;
            deq_reg       <= deq_next;
            enq_bytes_reg <= enq_bytes_next;
            deq_bytes_reg <= deq_bytes_next;
            if (load_res) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (commit_enq) begin
                tail_reg[pick] <= ring_next(tail_reg[pick]);
                fill_reg[pick] <= fill_reg[pick] + 1'b1;
            end
            if (commit_deq) begin
                head_reg[pick] <= ring_next(head_reg[pick]);
                fill_reg[pick] <= fill_reg[pick] - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[slot_addr] <= {q_op.handle, q_op.len};
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[slot_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_deq) begin
            sel_reg <= pick;
        end
        if (load_res) begin
            res_reg.status          <= st_out;
            res_reg.out_handle      <= h_out;
            res_reg.out_len         <= l_out;
            res_reg.served_class    <= SERVED_W'(c_out);
            res_reg.dropped_total   <= drop_next;
            res_reg.queued_total    <= enq_next;
            res_reg.sent_total      <= deq_next;
            res_reg.bytes_in_total  <= enq_bytes_next;
            res_reg.bytes_out_total <= deq_bytes_next;
        end
    end

endmodule

@@ hw/rtl/class_queue_priority_scheduler_unit.sv @@
// Top level of the class queue priority scheduler.
//
// s_* channel: one command transaction per handshake (enqueue to a class,
//   dequeue a named class, dequeue any class per sched_mode).
// m_* channel: one result transaction per command, in command order: status,
//   dequeued descriptor, served class and the global counters after that command.
// cfg_*: plain write port, sched_mode at index 0, fallback class at index 1;
//   write only while no command is in flight.
// Path: a command passes the front stage register and the command queue to the
//   result register; a successful dequeue also passes the descriptor read register.
// Throughput: one enqueue per cycle while m_ready is high; a successful dequeue
//   also holds the back end in BK_READ, as the descriptor memory read is registered.
// Structure: front end classifies commands into a 2-entry command queue; the
//   back end owns the rings, the 5120-entry descriptor memory and the counters.
// Reset: rings empty, counters zero, mode strict priority high first, default
//   class 0. Descriptor memory is not cleared; fill counts gate every read, so
//   commands are taken right after reset.
// Stall: while m_ready is low the result register holds, the command queue
//   fills behind it, and s_ready drops once the queue and front stage are full.
module class_queue_priority_scheduler_unit import cqps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // command channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [CSEL_W-1:0]     s_class_sel,
    input  logic [DATA_W-1:0]     s_pkt_handle,
    input  logic [DATA_W-1:0]     s_pkt_len,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [DATA_W-1:0]     m_out_handle,
    output logic [DATA_W-1:0]     m_out_len,
    output logic [SERVED_W-1:0]   m_served_class,
    output logic [PKT_CNT_W-1:0]  m_dropped_total,
    output logic [PKT_CNT_W-1:0]  m_queued_total,
    output logic [PKT_CNT_W-1:0]  m_sent_total,
    output logic [BYTE_CNT_W-1:0] m_bytes_in_total,
    output logic [BYTE_CNT_W-1:0] m_bytes_out_total
);

    // front stage -> command queue
    logic fr_valid, fr_ready;
    op_t  fr_op;
    // command queue -> back end
    logic bq_valid, bq_ready;
    op_t  bq_op;
    res_t res;

    cqps_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_class_sel  (s_class_sel),
        .s_pkt_handle (s_pkt_handle),
        .s_pkt_len    (s_pkt_len),
        .op_valid     (fr_valid),
        .op_ready     (fr_ready),
        .op           (fr_op)
    );

    cqps_cmdq u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_op     (fr_op),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_op    (bq_op)
    );

    cqps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (bq_valid),
        .q_ready   (bq_ready),
        .q_op      (bq_op),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    // result register fans out to the individual ports
    assign m_status          = res.status;
    assign m_out_handle      = res.out_handle;
    assign m_out_len         = res.out_len;
    assign m_served_class    = res.served_class;
    assign m_dropped_total   = res.dropped_total;
    assign m_queued_total    = res.queued_total;
    assign m_sent_total      = res.sent_total;
    assign m_bytes_in_total  = res.bytes_in_total;
    assign m_bytes_out_total = res.bytes_out_total;

endmodule

@@ hw/rtl/cqps_checker.sv @@
// Port-level checker for the scheduler top level, with its bind.
module cqps_checker import cqps_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [STATUS_W-1:0]   m_status,
    input logic [DATA_W-1:0]     m_out_handle,
    input logic [DATA_W-1:0]     m_out_len,
    input logic [SERVED_W-1:0]   m_served_class,
    input logic [PKT_CNT_W-1:0]  m_sent_total
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_handle)
            && $stable(m_status) && $stable(m_sent_total))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |->
            m_out_handle == '0 && m_out_len == '0 && m_served_class == '0)
        else $error("empty result carries data");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DROP |-> m_out_handle == '0 && m_out_len == '0)
        else $error("drop result carries data");

endmodule

bind class_queue_priority_scheduler_unit cqps_checker u_cqps_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_out_handle   (m_out_handle),
    .m_out_len      (m_out_len),
    .m_served_class (m_served_class),
    .m_sent_total   (m_sent_total)
);

@@ bench/class_queue_priority_scheduler_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the class queue priority scheduler: directed, overflow and random traffic.
module class_queue_priority_scheduler_unit_tb;
    import cqps_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_UNUSED        = 2'd3;
    localparam logic [MODE_W-1:0] MODE_DEFAULT_ONLY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE        = 2'd3;

    // Every input starts at a known value; reset is held from time zero.
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd        = '0;
    logic [CSEL_W-1:0]     s_class_sel  = '0;
    logic [DATA_W-1:0]     s_pkt_handle = '0;
    logic [DATA_W-1:0]     s_pkt_len    = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [DATA_W-1:0]     m_out_handle;
    logic [DATA_W-1:0]     m_out_len;
    logic [SERVED_W-1:0]   m_served_class;
    logic [PKT_CNT_W-1:0]  m_dropped_total;
    logic [PKT_CNT_W-1:0]  m_queued_total;
    logic [PKT_CNT_W-1:0]  m_sent_total;
    logic [BYTE_CNT_W-1:0] m_bytes_in_total;
    logic [BYTE_CNT_W-1:0] m_bytes_out_total;

    class_queue_priority_scheduler_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_class_sel       (s_class_sel),
        .s_pkt_handle      (s_pkt_handle),
        .s_pkt_len         (s_pkt_len),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_out_handle      (m_out_handle),
        .m_out_len         (m_out_len),
        .m_served_class    (m_served_class),
        .m_dropped_total   (m_dropped_total),
        .m_queued_total    (m_queued_total),
        .m_sent_total      (m_sent_total),
        .m_bytes_in_total  (m_bytes_in_total),
        .m_bytes_out_total (m_bytes_out_total)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the scheduler: per-class rings, global counters, registers
    // ------------------------------------------------------------------
    logic [31:0]           ring_desc [NUM_CLASSES][QUEUE_DEPTH]; // {handle, len}
    int                    ring_head [NUM_CLASSES];
    int                    ring_tail [NUM_CLASSES];
    int                    ring_fill [NUM_CLASSES];
    logic [PKT_CNT_W-1:0]  drop_count     = '0;
    logic [PKT_CNT_W-1:0]  enq_count      = '0;
    logic [PKT_CNT_W-1:0]  deq_count      = '0;
    logic [BYTE_CNT_W-1:0] enq_byte_count = '0;
    logic [BYTE_CNT_W-1:0] deq_byte_count = '0;
    logic [MODE_W-1:0]     mode_reg       = MODE_HIGH_FIRST;
    logic [DCLS_W-1:0]     dflt_reg       = '0;

    res_t                  expected_results [$];
    res_t                  oldest_expected;
    int                    mismatches      = 0;
    int                    results_checked = 0;

    // Idle stretches: each side flips between gappy and back-to-back now and then
    bit                    source_gappy    = 1'b1;
    bit                    sink_gappy      = 1'b1;

    initial begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            ring_head[c] = 0;
            ring_tail[c] = 0;
            ring_fill[c] = 0;
        end
    end

    // Out-of-range default class saturates to the top class.
    function automatic int fallback_class();
        return (dflt_reg < NUM_CLASSES) ? int'(dflt_reg) : NUM_CLASSES - 1;
    endfunction

    function automatic int next_slot(input int p);
        return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    // Pops the oldest descriptor of class c; an invalid or empty class gives nothing.
    function automatic bit pop_ring(input int c, output logic [31:0] desc);
        desc = '0;
        if (c >= NUM_CLASSES || ring_fill[c] == 0)
            return 1'b0;
        desc           = ring_desc[c][ring_head[c]];
        ring_head[c]   = next_slot(ring_head[c]);
        ring_fill[c]   = ring_fill[c] - 1;
        deq_count      = deq_count + 1'b1;
        deq_byte_count = deq_byte_count + desc[15:0];
        return 1'b1;
    endfunction

    // Applies one command to the shadow state and returns the result it must produce.
    function automatic res_t schedule_command(input logic [CMD_W-1:0]  cmd,
                                              input logic [CSEL_W-1:0] csel,
                                              input logic [DATA_W-1:0] handle,
                                              input logic [DATA_W-1:0] len);
        res_t        r;
        int          c;
        bit          got;
        logic [31:0] desc;
        r        = '0;
        r.status = ST_EMPTY;
        c        = 0;
        got      = 1'b0;
        desc     = '0;
        case (cmd)
            CMD_ENQ: begin
                // invalid class falls back to the default class
                c = (csel < NUM_CLASSES) ? int'(csel) : fallback_class();
                r.served_class = c[SERVED_W-1:0];
                if (ring_fill[c] >= QUEUE_DEPTH) begin
                    drop_count = drop_count + 1'b1;
                    r.status   = ST_DROP;
                end else begin
                    ring_desc[c][ring_tail[c]] = {handle, len};
                    ring_tail[c]   = next_slot(ring_tail[c]);
                    ring_fill[c]   = ring_fill[c] + 1;
                    enq_count      = enq_count + 1'b1;
                    enq_byte_count = enq_byte_count + len;
                    r.status       = ST_OK;
                end
            end
            CMD_DEQ_CLASS: begin
                c   = int'(csel);
                got = pop_ring(c, desc);
            end
            CMD_DEQ_ANY: begin
                if (mode_reg == MODE_HIGH_FIRST) begin
                    for (int k = NUM_CLASSES - 1; k >= 0 && !got; k--) begin
                        c   = k;
                        got = pop_ring(k, desc);
                    end
                end else if (mode_reg == MODE_LOW_FIRST) begin
                    for (int k = 0; k < NUM_CLASSES && !got; k++) begin
                        c   = k;
                        got = pop_ring(k, desc);
                    end
                end else begin
                    // default-only mode, and the spare mode code behaves the same
                    c   = fallback_class();
                    got = pop_ring(c, desc);
                end
            end
            default: ; // unused command: state untouched, "nothing" status
        endcase
        if (got) begin
            r.status       = ST_OK;
            r.out_handle   = desc[31:16];
            r.out_len      = desc[15:0];
            r.served_class = c[SERVED_W-1:0];
        end
        r.dropped_total   = drop_count;
        r.queued_total    = enq_count;
        r.sent_total      = deq_count;
        r.bytes_in_total  = enq_byte_count;
        r.bytes_out_total = deq_byte_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, msg);
    endfunction

    function automatic void compare_field(input string fname, input logic [47:0] want,
                                          input logic [47:0] got);
        if (want !== got)
            log_failure($sformatf("result %0d: %s expected 0x%0h got 0x%0h",
                                  results_checked, fname, want, got));
    endfunction

    // Each accepted result transaction is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                log_failure($sformatf("result %0d: unexpected transaction, status %0d",
                                      results_checked, m_status));
            end else begin
                oldest_expected = expected_results.pop_front();
                compare_field("status",          oldest_expected.status,          m_status);
                compare_field("out_handle",      oldest_expected.out_handle,      m_out_handle);
                compare_field("out_len",         oldest_expected.out_len,         m_out_len);
                compare_field("served_class",    oldest_expected.served_class,    m_served_class);
                compare_field("dropped_total",   oldest_expected.dropped_total,   m_dropped_total);
                compare_field("queued_total",    oldest_expected.queued_total,    m_queued_total);
                compare_field("sent_total",      oldest_expected.sent_total,      m_sent_total);
                compare_field("bytes_in_total",  oldest_expected.bytes_in_total,  m_bytes_in_total);
                compare_field("bytes_out_total", oldest_expected.bytes_out_total, m_bytes_out_total);
            end
            results_checked++;
        end
    end

    // Result sink: random stall before taking each transaction, quiet stretches too.
    initial begin : result_sink
        int stall;
        forever begin
            stall = sink_gappy ? $urandom_range(0, 13) : 0;
            if ($urandom_range(0, 39) == 0)
                sink_gappy = !sink_gappy;
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one command transaction; predicts its result at the accepting edge.
    task automatic send_command(input logic [CMD_W-1:0]  cmd,
                                input logic [CSEL_W-1:0] csel,
                                input logic [DATA_W-1:0] handle,
                                input logic [DATA_W-1:0] len);
        int gap;
        gap = source_gappy ? $urandom_range(0, 13) : 0;
        if ($urandom_range(0, 39) == 0)
            source_gappy = !source_gappy;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_class_sel  <= csel;
        s_pkt_handle <= handle;
        s_pkt_len    <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(schedule_command(cmd, csel, handle, len));
    endtask

    // Drops valid and waits until every result is back plus the pipeline depth.
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SCHED_MODE)
            mode_reg = value[MODE_W-1:0];
        else
            dflt_reg = value[DCLS_W-1:0];
    endtask

    // Registers change only with nothing in flight.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] mode_val,
                                  input logic [CFG_DATA_W-1:0] dflt_val);
        settle_block();
        write_register(CFG_SCHED_MODE, mode_val);
        write_register(CFG_FALLBACK_CLASS, dflt_val);
    endtask

    // Random 16-bit word, biased toward the extremes.
    function automatic logic [DATA_W-1:0] draw_word();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return DATA_W'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every command, both empty cases, invalid classes and field extremes.
    task automatic test_directed_commands();
        send_command(CMD_DEQ_ANY,   4'd0,  16'h0000, 16'h0000); // nothing queued
        send_command(CMD_DEQ_CLASS, 4'd3,  16'hFFFF, 16'hFFFF); // named class empty
        send_command(CMD_ENQ,       4'd0,  16'h0000, 16'h0000);
        send_command(CMD_ENQ,       4'd4,  16'hFFFF, 16'hFFFF);
        send_command(CMD_ENQ,       4'd2,  16'h1234, 16'h0001);
        send_command(CMD_ENQ,       4'd15, 16'hA5A5, 16'h5A5A); // invalid -> default class
        send_command(CMD_ENQ,       4'd5,  16'h5A5A, 16'hA5A5); // first invalid class
        send_command(CMD_UNUSED,    4'd4,  16'hFFFF, 16'hFFFF); // no state change
        send_command(CMD_DEQ_CLASS, 4'd9,  16'h0000, 16'h0000); // invalid named class
        send_command(CMD_DEQ_CLASS, 4'd2,  16'h0000, 16'h0000);
        send_command(CMD_DEQ_ANY,   4'd0,  16'h0000, 16'h0000); // highest class first
        send_command(CMD_DEQ_ANY,   4'd0,  16'h0000, 16'h0000);
        send_command(CMD_DEQ_CLASS, 4'd0,  16'h0000, 16'h0000);
        send_command(CMD_DEQ_ANY,   4'd0,  16'h0000, 16'h0000);
        send_command(CMD_DEQ_ANY,   4'd0,  16'h0000, 16'h0000); // empty again
    endtask

    // Lowest-first order, then the spare mode code with a saturating default class.
    task automatic test_directed_modes();
        apply_settings({1'b0, MODE_LOW_FIRST}, 3'd3);
        send_command(CMD_ENQ,     4'd3,  16'h0303, 16'h0030);
        send_command(CMD_ENQ,     4'd1,  16'h0101, 16'h0010);
        send_command(CMD_ENQ,     4'd12, 16'h0C0C, 16'h00C0); // lands in class 3
        send_command(CMD_DEQ_ANY, 4'd0,  16'h0000, 16'h0000);
        send_command(CMD_DEQ_ANY, 4'd0,  16'h0000, 16'h0000);
        apply_settings({1'b0, MODE_SPARE}, 3'd7);              // default saturates to top
        send_command(CMD_ENQ,     4'd8,  16'h8888, 16'h0888);
        send_command(CMD_DEQ_ANY, 4'd0,  16'h0000, 16'h0000);
        send_command(CMD_DEQ_ANY, 4'd0,  16'h0000, 16'h0000); // class 3 still holds one
        send_command(CMD_DEQ_CLASS, 4'd3, 16'h0000, 16'h0000);
    endtask

    // Fills the top class until it drops, then drains it past the ring wrap
    // with a trickle of fresh enqueues.
    task automatic test_ring_overflow();
        int                top_cls;
        logic [CSEL_W-1:0] enq_sel;
        int                pick;
        top_cls = NUM_CLASSES - 1;
        apply_settings({1'b0, MODE_DEFAULT_ONLY}, 3'd6);       // default saturates to top
        while (ring_fill[top_cls] < QUEUE_DEPTH) begin
            enq_sel = $urandom_range(0, 1) ? CSEL_W'(top_cls) : CSEL_W'($urandom_range(5, 15));
            send_command(CMD_ENQ, enq_sel, draw_word(), draw_word());
        end
        repeat (4)
            send_command(CMD_ENQ, CSEL_W'(top_cls), draw_word(), draw_word());
        while (ring_fill[top_cls] != 0) begin
            pick = $urandom_range(0, 63);
            if (pick == 0)
                send_command(CMD_ENQ, CSEL_W'($urandom_range(4, 15)), draw_word(), draw_word());
            else if (pick < 32)
                send_command(CMD_DEQ_CLASS, CSEL_W'(top_cls), draw_word(), draw_word());
            else
                send_command(CMD_DEQ_ANY, CSEL_W'($urandom()), draw_word(), draw_word());
        end
    endtask

    // Mixed traffic over several register settings; the first four hit the extremes.
    task automatic test_random_traffic();
        logic [MODE_W-1:0]     mode_val;
        logic [CFG_DATA_W-1:0] dflt_val;
        logic [CMD_W-1:0]      cmd;
        logic [CSEL_W-1:0]     csel;
        int                    pick;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin mode_val = MODE_HIGH_FIRST;   dflt_val = 3'd0; end
                1: begin mode_val = MODE_LOW_FIRST;    dflt_val = 3'd4; end
                2: begin mode_val = MODE_DEFAULT_ONLY; dflt_val = 3'd5; end
                3: begin mode_val = MODE_SPARE;        dflt_val = 3'd7; end
                default: begin
                    mode_val = MODE_W'($urandom_range(0, 3));
                    dflt_val = CFG_DATA_W'($urandom_range(0, 7));
                end
            endcase
            // the spare top bit of a mode write is ignored by the register
            apply_settings({1'($urandom_range(0, 1)), mode_val}, dflt_val);
            repeat (20) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    cmd = CMD_ENQ;
                else if (pick < 65)
                    cmd = CMD_DEQ_CLASS;
                else if (pick < 95)
                    cmd = CMD_DEQ_ANY;
                else
                    cmd = CMD_UNUSED;
                if ($urandom_range(0, 4) == 0)
                    csel = CSEL_W'($urandom_range(NUM_CLASSES, 15));
                else
                    csel = CSEL_W'($urandom_range(0, NUM_CLASSES - 1));
                send_command(cmd, csel, draw_word(), draw_word());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_directed_modes();
        test_ring_overflow();
        test_random_traffic();
        settle_block();
        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cqps_pkg.sv
hw/rtl/cqps_front.sv
hw/rtl/cqps_cmdq.sv
hw/rtl/cqps_back.sv
hw/rtl/class_queue_priority_scheduler_unit.sv
hw/rtl/cqps_checker.sv
bench/class_queue_priority_scheduler_unit_tb.sv
